// ===== sv/memory_region_map_table_unit_assert.svh =====
// Assertion macros for the memory region map table unit.
// Used by the top level; needs clk_i and rst_ni in scope.
`ifndef MEMORY_REGION_MAP_TABLE_UNIT_ASSERT_SVH
`define MEMORY_REGION_MAP_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define MRMT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mrmt: same-cycle check failed");

// next-cycle implication
`define MRMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mrmt: next-cycle check failed");

`endif

// ===== sv/mrmt_pkg.sv =====
// Shared types, codes and constants for the memory region map table.
// No dependencies.
package mrmt_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned CNT_W = 7;
  // page size must be a power of two
  localparam int unsigned PAGE_BYTES = 4096;
  localparam logic [63:0] PAGE_MASK = 64'(PAGE_BYTES - 1);

  // operation codes
  localparam logic [2:0] OP_APPEND   = 3'd0;
  localparam logic [2:0] OP_CLAIM_AT = 3'd1;
  localparam logic [2:0] OP_CLAIM_FF = 3'd2;
  localparam logic [2:0] OP_FINALIZE = 3'd3;
  localparam logic [2:0] OP_READ     = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NO_HOST = 2'd2;
  localparam logic [1:0] ST_BAD     = 2'd3;

  // region kinds
  localparam logic [2:0] KIND_INVALID  = 3'd0;
  localparam logic [2:0] KIND_FREE     = 3'd1;
  localparam logic [2:0] KIND_RESERVED = 3'd2;
  localparam logic [2:0] KIND_LAST     = 3'd6;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] len;
    logic [2:0]  kind;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic        sub;
  } alu_req_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_READ_EV, S_ALIGN, S_RANGE,
    S_SC_RD, S_SC_OFF, S_SC_REST, S_SC_FIT, S_SPLIT, S_SP_A, S_SP_B, S_SP_C,
    S_F1_IRD, S_F1_IEV, S_F1_JRD, S_F1_JEV,
    S_F2_IRD, S_F2_IEV, S_F2_JRD, S_F2_JEV, S_F2_JE2, S_F2_JMRG, S_F2_IWB,
    S_F3_RD, S_F3_EV,
    S_F4_IRD, S_F4_IEV, S_F4_JRD, S_F4_JEV, S_F4_PUT, S_DONE
  } state_e;

  function automatic logic kind_ok(input logic [2:0] k);
    return (k != KIND_INVALID) && (k <= KIND_LAST);
  endfunction

endpackage

// ===== sv/mrmt_mem.sv =====
// Region table storage: one write port, one registered read port.
// Depends on mrmt_pkg.
module mrmt_mem import mrmt_pkg::*; (
  input  logic             clk_i,
  input  mem_wr_t          wr_i,
  input  logic [IDX_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mrmt_alu.sv =====
// Shared 64-bit add/subtract unit with carry-out or borrow flag.
// Depends on mrmt_pkg.
module mrmt_alu import mrmt_pkg::*; (
  input  alu_req_t    req_i,
  output logic [63:0] res_o,
  output logic        flag_o
);

  logic [64:0] sum;

  // subtract is a + ~b + 1; flag is borrow for subtract, carry for add
  assign sum    = {1'b0, req_i.a} + {1'b0, (req_i.sub ? ~req_i.b : req_i.b)}
                  + {64'd0, req_i.sub};
  assign res_o  = sum[63:0];
  assign flag_o = req_i.sub ? ~sum[64] : sum[64];

endmodule

// ===== sv/memory_region_map_table_unit.sv =====
// Channel  | Signals                                          | Handshake
// command  | operation_i, region_*_i, any_host_i, entry_index_i | start_i while !busy_o
// result   | status_o, out_*_o, entry_total_o                 | done_o, one cycle
//
// One command at a time; busy_o is high from acceptance until the result beat.
// A claim reads the entries one by one until it finds a host, then writes the split;
// finalize walks the table with one memory read port and one shared adder.
// Reset clears the state and the entry count only; no clearing pass over the table.
// The receiver cannot stall: the result beat is shown for exactly one cycle.
// Depends on mrmt_pkg, mrmt_mem, mrmt_alu and the assertion macro header.
module memory_region_map_table_unit import mrmt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  operation_i,
  input  logic [63:0] region_address_i,
  input  logic [63:0] region_size_i,
  input  logic [2:0]  region_kind_i,
  input  logic        any_host_i,
  input  logic [5:0]  entry_index_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [63:0] out_address_o,
  output logic [63:0] out_size_o,
  output logic [2:0]  out_kind_o,
  output logic [6:0]  entry_total_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] i_q, i_d, j_q, j_d, n_q, n_d, v_q, v_d;
  logic [2:0]       op_q, op_d, kind_q, kind_d;
  logic [63:0]      addr_q, addr_d, size_q, size_d;
  logic             any_q, any_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [63:0]      alen_q, alen_d, end_q, end_d, off_q, off_d, tail_q, tail_d;
  logic [63:0]      endi_q, endi_d;
  logic             ci_q, ci_d, aij_q, aij_d;
  entry_t           host_q, host_d, ei_q, ei_d, ej_q, ej_d;
  logic [1:0]       rs_q, rs_d;
  logic [63:0]      ra_q, ra_d, rsz_q, rsz_d;
  logic [2:0]       rk_q, rk_d;

  mem_wr_t          wr;
  logic [IDX_W-1:0] raddr;
  entry_t           rdata;
  alu_req_t         alu_req;
  logic [63:0]      alu_res, rem;
  logic             alu_flag, adj_ij, adj_ji;
  logic [1:0]       need;
  logic [CNT_W-1:0] room, v_nx;

  mrmt_mem u_mem (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mrmt_alu u_alu (
    .req_i  (alu_req),
    .res_o  (alu_res),
    .flag_o (alu_flag)
  );

  // split bookkeeping
  assign rem    = size_q & PAGE_MASK;
  assign need   = ((off_q != 64'd0) && (tail_q != 64'd0)) ? 2'd2 :
                  (((off_q == 64'd0) && (tail_q == 64'd0)) ? 2'd0 : 2'd1);
  assign room   = CNT_W'(DEPTH) - count_q;
  assign adj_ij = !ci_q && !alu_flag && (endi_q == ej_q.base);
  assign adj_ji = !ci_q && !alu_flag && (alu_res == ei_q.base);
  assign v_nx   = kind_ok(rdata.kind) ? v_q + 1'b1 : v_q;

  // state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;  j_q <= j_d;  n_q <= n_d;  v_q <= v_d;
    op_q <= op_d;  kind_q <= kind_d;  addr_q <= addr_d;  size_q <= size_d;
    any_q <= any_d;  idx_q <= idx_d;
    alen_q <= alen_d;  end_q <= end_d;  off_q <= off_d;  tail_q <= tail_d;
    endi_q <= endi_d;  ci_q <= ci_d;  aij_q <= aij_d;
    host_q <= host_d;  ei_q <= ei_d;  ej_q <= ej_d;
    rs_q <= rs_d;  ra_q <= ra_d;  rsz_q <= rsz_d;  rk_q <= rk_d;
  end

  // sequencer
  always_comb begin
    state_d = state_q;  count_d = count_q;
    i_d = i_q;  j_d = j_q;  n_d = n_q;  v_d = v_q;
    op_d = op_q;  kind_d = kind_q;  addr_d = addr_q;  size_d = size_q;
    any_d = any_q;  idx_d = idx_q;
    alen_d = alen_q;  end_d = end_q;  off_d = off_q;  tail_d = tail_q;
    endi_d = endi_q;  ci_d = ci_q;  aij_d = aij_q;
    host_d = host_q;  ei_d = ei_q;  ej_d = ej_q;
    rs_d = rs_q;  ra_d = ra_q;  rsz_d = rsz_q;  rk_d = rk_q;
    wr      = '0;
    raddr   = i_q[IDX_W-1:0];
    alu_req = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d = operation_i;  addr_d = region_address_i;  size_d = region_size_i;
          kind_d = region_kind_i;  any_d = any_host_i;  idx_d = entry_index_i;
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        rs_d = ST_BAD;  ra_d = '0;  rsz_d = '0;  rk_d = KIND_INVALID;
        state_d = S_DONE;
        case (op_q)
          OP_APPEND: begin
            if (!kind_ok(kind_q)) begin
              rs_d = ST_BAD;
            end else if (count_q >= CNT_W'(DEPTH)) begin
              rs_d = ST_FULL;
            end else begin
              wr.we = 1'b1;  wr.addr = count_q[IDX_W-1:0];
              wr.data = '{base: addr_q, len: size_q, kind: kind_q};
              count_d = count_q + 1'b1;
              rs_d = ST_OK;
            end
          end
          OP_CLAIM_AT, OP_CLAIM_FF: state_d = S_ALIGN;
          OP_FINALIZE: begin
            n_d = count_q;  i_d = '0;
            if (count_q == '0) rs_d = ST_OK;
            else state_d = S_F1_IRD;
          end
          OP_READ: begin
            raddr = idx_q;
            if ({1'b0, idx_q} < count_q) state_d = S_READ_EV;
          end
          default: rs_d = ST_BAD;
        endcase
      end

      S_READ_EV: begin
        raddr = idx_q;
        rs_d = ST_OK;  ra_d = rdata.base;  rsz_d = rdata.len;  rk_d = rdata.kind;
        state_d = S_DONE;
      end

      // round the size up to a page
      S_ALIGN: begin
        alu_req.a = size_q;
        alu_req.b = (rem == 64'd0) ? 64'd0 : (64'(PAGE_BYTES) - rem);
        alen_d = alu_res;  i_d = '0;
        if (!kind_ok(kind_q) || size_q == 64'd0 || alu_flag) begin
          state_d = S_DONE;
        end else if (op_q == OP_CLAIM_AT) begin
          state_d = S_RANGE;
        end else if (count_q == '0) begin
          rs_d = ST_NO_HOST;  state_d = S_DONE;
        end else begin
          state_d = S_SC_RD;
        end
      end

      S_RANGE: begin
        alu_req.a = addr_q;  alu_req.b = alen_q;
        end_d = alu_res;
        if (addr_q == 64'd0 || alu_flag) state_d = S_DONE;
        else if (count_q == '0) begin
          rs_d = ST_NO_HOST;  state_d = S_DONE;
        end else state_d = S_SC_RD;
      end

      // host scan, one entry over several steps of the shared adder
      S_SC_RD: state_d = S_SC_OFF;

      S_SC_OFF: begin
        host_d = rdata;
        alu_req.sub = 1'b1;
        if (op_q == OP_CLAIM_AT) begin
          alu_req.a = addr_q;  alu_req.b = rdata.base;
          off_d = alu_res;
          if (!kind_ok(rdata.kind) || (!any_q && rdata.kind != KIND_FREE) || alu_flag)
            state_d = S_SC_FIT;
          else state_d = S_SC_REST;
          if (state_d == S_SC_FIT) begin
            if (i_q + 1'b1 >= count_q) begin
              rs_d = ST_NO_HOST;  state_d = S_DONE;
            end else begin
              i_d = i_q + 1'b1;  state_d = S_SC_RD;
            end
          end
        end else begin
          alu_req.a = rdata.len;  alu_req.b = alen_q;
          tail_d = alu_res;  off_d = '0;
          if (rdata.kind != KIND_FREE || alu_flag) begin
            if (i_q + 1'b1 >= count_q) begin
              rs_d = ST_NO_HOST;  state_d = S_DONE;
            end else begin
              i_d = i_q + 1'b1;  state_d = S_SC_RD;
            end
          end else state_d = S_SC_REST;
        end
      end

      S_SC_REST: begin
        if (op_q == OP_CLAIM_AT) begin
          alu_req.sub = 1'b1;  alu_req.a = host_q.len;  alu_req.b = off_q;
          tail_d = alu_res;
        end else begin
          alu_req.a = host_q.base;  alu_req.b = alen_q;
          end_d = alu_res;  addr_d = host_q.base;
        end
        if (alu_flag) begin
          if (i_q + 1'b1 >= count_q) begin
            rs_d = ST_NO_HOST;  state_d = S_DONE;
          end else begin
            i_d = i_q + 1'b1;  state_d = S_SC_RD;
          end
        end else state_d = (op_q == OP_CLAIM_AT) ? S_SC_FIT : S_SPLIT;
      end

      S_SC_FIT: begin
        alu_req.sub = 1'b1;  alu_req.a = tail_q;  alu_req.b = alen_q;
        tail_d = alu_res;
        if (alu_flag) begin
          if (i_q + 1'b1 >= count_q) begin
            rs_d = ST_NO_HOST;  state_d = S_DONE;
          end else begin
            i_d = i_q + 1'b1;  state_d = S_SC_RD;
          end
        end else state_d = S_SPLIT;
      end

      S_SPLIT: begin
        if (CNT_W'(need) > room) begin
          rs_d = ST_FULL;  state_d = S_DONE;
        end else state_d = S_SP_A;
      end

      // split writes: new entries at the end, host rewritten last
      S_SP_A: begin
        wr.we = 1'b1;
        if (need == 2'd0) begin
          wr.addr = i_q[IDX_W-1:0];
          wr.data = '{base: host_q.base, len: host_q.len, kind: kind_q};
          rs_d = ST_OK;  ra_d = addr_q;  rsz_d = alen_q;  rk_d = kind_q;
          state_d = S_DONE;
        end else if (off_q == 64'd0) begin
          wr.addr = count_q[IDX_W-1:0];
          wr.data = '{base: end_q, len: tail_q, kind: host_q.kind};
          count_d = count_q + 1'b1;  state_d = S_SP_C;
        end else begin
          wr.addr = count_q[IDX_W-1:0];
          wr.data = '{base: addr_q, len: alen_q, kind: kind_q};
          count_d = count_q + 1'b1;
          state_d = (tail_q != 64'd0) ? S_SP_B : S_SP_C;
        end
      end

      S_SP_B: begin
        wr.we = 1'b1;  wr.addr = count_q[IDX_W-1:0];
        wr.data = '{base: end_q, len: tail_q, kind: host_q.kind};
        count_d = count_q + 1'b1;  state_d = S_SP_C;
      end

      S_SP_C: begin
        wr.we = 1'b1;  wr.addr = i_q[IDX_W-1:0];
        if (off_q == 64'd0) wr.data = '{base: addr_q, len: alen_q, kind: kind_q};
        else wr.data = '{base: host_q.base, len: off_q, kind: host_q.kind};
        rs_d = ST_OK;  ra_d = addr_q;  rsz_d = alen_q;  rk_d = kind_q;
        state_d = S_DONE;
      end

      // finalize pass 1: drop repeated reserved entries
      S_F1_IRD: state_d = S_F1_IEV;

      S_F1_IEV: begin
        ei_d = rdata;
        if (rdata.kind == KIND_RESERVED && i_q + 1'b1 < n_q) begin
          j_d = i_q + 1'b1;  state_d = S_F1_JRD;
        end else if (i_q + 1'b1 < n_q) begin
          i_d = i_q + 1'b1;  state_d = S_F1_IRD;
        end else begin
          i_d = '0;  state_d = S_F2_IRD;
        end
      end

      S_F1_JRD: begin
        raddr = j_q[IDX_W-1:0];  state_d = S_F1_JEV;
      end

      S_F1_JEV: begin
        raddr = j_q[IDX_W-1:0];
        if (rdata == ei_q) begin
          wr.we = 1'b1;  wr.addr = j_q[IDX_W-1:0];
        end
        if (j_q + 1'b1 < n_q) begin
          j_d = j_q + 1'b1;  state_d = S_F1_JRD;
        end else if (i_q + 1'b1 < n_q) begin
          i_d = i_q + 1'b1;  state_d = S_F1_IRD;
        end else begin
          i_d = '0;  state_d = S_F2_IRD;
        end
      end

      // finalize pass 2: merge touching entries of one kind into entry i
      S_F2_IRD: state_d = S_F2_IEV;

      S_F2_IEV: begin
        ei_d = rdata;  j_d = '0;
        if (rdata.kind != KIND_INVALID) state_d = S_F2_JRD;
        else if (i_q + 1'b1 < n_q) begin
          i_d = i_q + 1'b1;  state_d = S_F2_IRD;
        end else begin
          i_d = '0;  v_d = '0;  state_d = S_F3_RD;
        end
      end

      S_F2_JRD: begin
        raddr = j_q[IDX_W-1:0];
        if (j_q != i_q) state_d = S_F2_JEV;
        else if (j_q + 1'b1 < n_q) j_d = j_q + 1'b1;
        else state_d = S_F2_IWB;
      end

      S_F2_JEV: begin
        raddr = j_q[IDX_W-1:0];
        ej_d = rdata;
        alu_req.a = ei_q.base;  alu_req.b = ei_q.len;
        endi_d = alu_res;  ci_d = alu_flag;
        if (rdata.kind == KIND_INVALID || rdata.kind != ei_q.kind) begin
          if (j_q + 1'b1 < n_q) begin
            j_d = j_q + 1'b1;  state_d = S_F2_JRD;
          end else state_d = S_F2_IWB;
        end else state_d = S_F2_JE2;
      end

      S_F2_JE2: begin
        alu_req.a = ej_q.base;  alu_req.b = ej_q.len;
        aij_d = adj_ij;
        if (adj_ij || adj_ji) state_d = S_F2_JMRG;
        else if (j_q + 1'b1 < n_q) begin
          j_d = j_q + 1'b1;  state_d = S_F2_JRD;
        end else state_d = S_F2_IWB;
      end

      S_F2_JMRG: begin
        alu_req.a = ei_q.len;  alu_req.b = ej_q.len;
        ei_d.len = alu_res;
        if (!aij_q) ei_d.base = ej_q.base;
        wr.we = 1'b1;  wr.addr = j_q[IDX_W-1:0];
        if (j_q + 1'b1 < n_q) begin
          j_d = j_q + 1'b1;  state_d = S_F2_JRD;
        end else state_d = S_F2_IWB;
      end

      S_F2_IWB: begin
        wr.we = 1'b1;  wr.addr = i_q[IDX_W-1:0];  wr.data = ei_q;
        if (i_q + 1'b1 < n_q) begin
          i_d = i_q + 1'b1;  state_d = S_F2_IRD;
        end else begin
          i_d = '0;  v_d = '0;  state_d = S_F3_RD;
        end
      end

      // finalize pass 3: compact valid entries to the front
      S_F3_RD: state_d = S_F3_EV;

      S_F3_EV: begin
        if (kind_ok(rdata.kind)) begin
          wr.we = 1'b1;  wr.addr = v_q[IDX_W-1:0];  wr.data = rdata;
        end
        v_d = v_nx;
        if (i_q + 1'b1 < n_q) begin
          i_d = i_q + 1'b1;  state_d = S_F3_RD;
        end else begin
          count_d = v_nx;  i_d = CNT_W'(1);
          if (v_nx <= CNT_W'(1)) begin
            rs_d = ST_OK;  ra_d = '0;  rsz_d = '0;  rk_d = KIND_INVALID;
            state_d = S_DONE;
          end else state_d = S_F4_IRD;
        end
      end

      // finalize pass 4: stable insertion sort by start address
      S_F4_IRD: state_d = S_F4_IEV;

      S_F4_IEV: begin
        ei_d = rdata;  j_d = i_q;  state_d = S_F4_JRD;
      end

      S_F4_JRD: begin
        raddr = IDX_W'(j_q - 1'b1);
        state_d = (j_q == '0) ? S_F4_PUT : S_F4_JEV;
      end

      S_F4_JEV: begin
        raddr = IDX_W'(j_q - 1'b1);
        if (rdata.base > ei_q.base) begin
          wr.we = 1'b1;  wr.addr = j_q[IDX_W-1:0];  wr.data = rdata;
          j_d = j_q - 1'b1;  state_d = S_F4_JRD;
        end else state_d = S_F4_PUT;
      end

      S_F4_PUT: begin
        wr.we = 1'b1;  wr.addr = j_q[IDX_W-1:0];  wr.data = ei_q;
        if (i_q + 1'b1 < v_q) begin
          i_d = i_q + 1'b1;  state_d = S_F4_IRD;
        end else begin
          rs_d = ST_OK;  ra_d = '0;  rsz_d = '0;  rk_d = KIND_INVALID;
          state_d = S_DONE;
        end
      end

      S_DONE: state_d = S_IDLE;

      default: state_d = S_IDLE;
    endcase
  end

  // result beat
  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = (state_q == S_DONE);
  assign status_o      = rs_q;
  assign out_address_o = ra_q;
  assign out_size_o    = rsz_q;
  assign out_kind_o    = rk_q;
  assign entry_total_o = count_q;

`include "memory_region_map_table_unit_assert.svh"

  `MRMT_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH))
  `MRMT_ASSERT_SAME(a_done_busy, done_o, busy_o)
  `MRMT_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o)
  `MRMT_ASSERT_NEXT(a_done_idle, done_o, !busy_o)
  `MRMT_ASSERT_NEXT(a_idle_count, !busy_o, $stable(count_q))

endmodule
